@@ design/kpm_pkg.sv @@
// shared types and constants for the kronecker product times matrix engine
// no dependencies; used by kpm_mac and kronecker_product_times_matrix
package kpm_pkg;

  // operation codes carried in tuser of the input channel
  localparam logic [1:0] OP_LOAD_A  = 2'd0;
  localparam logic [1:0] OP_LOAD_B  = 2'd1;
  localparam logic [1:0] OP_LOAD_C  = 2'd2;
  localparam logic [1:0] OP_COMPUTE = 2'd3;

  // configuration register indexes
  localparam logic [2:0] REG_ROWS_A = 3'd0;
  localparam logic [2:0] REG_COLS_A = 3'd1;
  localparam logic [2:0] REG_ROWS_B = 3'd2;
  localparam logic [2:0] REG_COLS_B = 3'd3;
  localparam logic [2:0] REG_COLS_C = 3'd4;

  // accumulator width: 48x32 products summed over up to 16 terms
  localparam int ACC_W = 88;

  // flags that travel with one multiply beat down the datapath
  typedef struct packed {
    logic first;   // first term of a dot product
    logic last;    // last term of a dot product
    logic stage2;  // second product (P times transpose A)
    logic upper;   // upper half of a split 48-bit operand
    logic tail;    // final element of the emitted column
    logic psat;    // stage-one entry feeding this term was clipped
  } beat_t;

endpackage

@@ design/kpm_mac.sv @@
// multiply, accumulate, round and saturate datapath of the kronecker engine
// depends on kpm_pkg (beat_t, ACC_W)
module kpm_mac #(
  parameter int FRAC_BITS = 16,
  parameter int TW = 6
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic                in_valid,
  input  kpm_pkg::beat_t      in_flags,
  input  logic [TW-1:0]       in_tag,
  input  logic signed [32:0]  op_x,
  input  logic signed [31:0]  op_y,
  output logic                res_valid,
  output kpm_pkg::beat_t      res_flags,
  output logic [TW-1:0]       res_tag,
  output logic signed [47:0]  res_value,
  output logic                res_sat,
  output logic                busy
);

  localparam int AW_ = kpm_pkg::ACC_W;
  localparam logic [AW_-1:0] HALF = (AW_'(1) << FRAC_BITS) >> 1;

  logic                  p2v_r, p3v_r;
  kpm_pkg::beat_t        p2f_r, p3f_r;
  logic [TW-1:0]         p2tag_r, p3tag_r;
  logic signed [AW_-1:0] prod_r, acc_r, acc_nxt, prod_nxt;
  logic                  sacc_r, sacc_nxt;
  logic signed [64:0]    mul;
  logic signed [AW_-1:0] rnd, sh;
  logic                  ok48, ok32, ok;

  assign mul = op_x * op_y;

  always_comb begin
    prod_nxt = {{(AW_-65){mul[64]}}, mul};
    if (in_flags.upper) begin
      prod_nxt = prod_nxt <<< 24;
    end
  end

  assign acc_nxt  = (p2f_r.first ? '0 : acc_r) + prod_r;
  assign sacc_nxt = (p2f_r.first ? 1'b0 : sacc_r) | p2f_r.psat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2v_r <= 1'b0;
      p3v_r <= 1'b0;
    end else if (adv) begin
      p2v_r <= in_valid;
      p3v_r <= p2v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p2f_r   <= in_flags;
      p2tag_r <= in_tag;
      prod_r  <= prod_nxt;
      p3f_r   <= p2f_r;
      p3tag_r <= p2tag_r;
      if (p2v_r) begin
        acc_r  <= acc_nxt;
        sacc_r <= sacc_nxt;
      end
    end
  end

  // round half up, then clip to 48 bits (stage one) or 32 bits (stage two)
  assign rnd  = acc_r + HALF;
  assign sh   = rnd >>> FRAC_BITS;
  assign ok48 = (&sh[AW_-1:47]) | ~(|sh[AW_-1:47]);
  assign ok32 = (&sh[AW_-1:31]) | ~(|sh[AW_-1:31]);
  assign ok   = p3f_r.stage2 ? ok32 : ok48;

  always_comb begin
    if (ok) begin
      res_value = sh[47:0];
    end else if (p3f_r.stage2) begin
      res_value = sh[AW_-1] ? 48'shffff_8000_0000 : 48'sh0000_7fff_ffff;
    end else begin
      res_value = sh[AW_-1] ? 48'sh8000_0000_0000 : 48'sh7fff_ffff_ffff;
    end
  end

  assign res_valid = p3v_r && p3f_r.last;
  assign res_flags = p3f_r;
  assign res_tag   = p3tag_r;
  assign res_sat   = !ok || sacc_r;
  assign busy      = p2v_r || p3v_r;

endmodule

@@ design/kronecker_product_times_matrix.sv @@
// top level of the kronecker product times matrix engine
// depends on kpm_pkg and kpm_mac
//
// usage:
//  - configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data) sets the five
//    matrix sizes; cfg_ready is always high, writes only while the block is idle
//  - input channel carries one word per item: tuser is the operation, tdata the
//    column-major position and the Q16.16 element; loads may come back to back
//  - a compute word names a column j of C and produces rows_a*rows_b words on
//    the output channel, column-major, the final one with tlast set; tuser
//    flags a saturated element
//  - a compute runs stage one (B times Cj, cols_a*rows_b*cols_b terms) then
//    stage two (P times transpose A, rows_a*rows_b*cols_a terms, two beats
//    each since the 48-bit partial is split into halves for the multiplier);
//    one multiplier retires one beat per cycle unless the output register stalls
//  - in_tready is high only while no compute is in flight
//  - receiver stall: the whole datapath freezes while the output register
//    holds an untaken word, nothing is dropped
//  - reset clears sizes and control; stores are undefined until loaded
module kronecker_product_times_matrix #(
  parameter int MAX_DIM   = 8,
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // config write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [3:0]  cfg_data,
  // input word channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // [8:0] position, [40:9] element_value, rest zero
  input  logic [1:0]  in_tuser,   // [1:0] operation
  // result word channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [31:0] result_value, [37:32] result_row,
                                  // [40:38] result_column, rest zero
  output logic        out_tuser,  // [0] saturated
  output logic        out_tlast   // last element of the column
);

  localparam int SQ   = MAX_DIM * MAX_DIM;
  localparam int CUBE = SQ * MAX_DIM;
  localparam int AW   = (SQ > 1) ? $clog2(SQ) : 1;
  localparam int CW   = (CUBE > 1) ? $clog2(CUBE) : 1;
  localparam int DW   = $clog2(MAX_DIM + 1);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_ONE   = 5'b00010,
    ST_DRAIN = 5'b00100,
    ST_TWO   = 5'b01000,
    ST_FIN   = 5'b10000
  } state_t;

  function automatic logic [DW-1:0] eff(input logic [3:0] v);
    if ({28'd0, v} > 32'(MAX_DIM)) begin
      return DW'(MAX_DIM);
    end
    return DW'(v);
  endfunction

  // size registers
  logic [3:0] rows_a_r, cols_a_r, rows_b_r, cols_b_r, cols_c_r;
  logic [DW-1:0] ra, ca, rb, cb, cc;

  // element stores
  logic [31:0] a_mem [SQ];
  logic [31:0] b_mem [SQ];
  logic [31:0] c_mem [CUBE];
  logic [48:0] p_mem [SQ];   // [48] clipped flag, [47:0] partial

  // sequencer
  state_t        st_r;
  logic [DW-1:0] o_r, m_r, k_r;
  logic          hi_r;
  logic [AW-1:0] xp_r, dpi_r;
  logic [CW-1:0] yp_r, cbase_r;
  logic [2:0]    col_r;

  // read stage
  logic           p1v_r;
  kpm_pkg::beat_t p1f_r;
  logic [AW-1:0]  p1tag_r;
  logic [31:0]    a_rd_r, b_rd_r, c_rd_r;
  logic [48:0]    p_rd_r;

  // output register
  logic        out_v_r, out_sat_r, out_last_r;
  logic [31:0] out_val_r;
  logic [5:0]  out_row_r;
  logic [2:0]  out_col_r;

  logic [8:0]      pos;
  logic [31:0]     val;
  logic            in_acc, go;
  logic [2*DW-1:0] lim_a, lim_b, nrc, total;
  logic [3*DW-1:0] lim_c, cb_full;
  logic [CW-1:0]   cbase_new;
  logic            adv, stg1, iss, kl, k_end, m_end, o_end, busy;
  logic [DW-1:0]   kmax, omax;
  kpm_pkg::beat_t  beat, mflags;
  logic signed [32:0] op_x;
  logic signed [31:0] op_y;

  logic                  res_valid, res_sat, mac_busy;
  kpm_pkg::beat_t        res_flags;
  logic [AW-1:0]         res_tag;
  logic signed [47:0]    res_value;

  assign ra = eff(rows_a_r);
  assign ca = eff(cols_a_r);
  assign rb = eff(rows_b_r);
  assign cb = eff(cols_b_r);
  assign cc = eff(cols_c_r);

  assign pos    = in_tdata[8:0];
  assign val    = in_tdata[40:9];
  assign in_acc = in_tvalid && in_tready;

  assign lim_a = (2*DW)'(ra) * (2*DW)'(ca);
  assign lim_b = (2*DW)'(rb) * (2*DW)'(cb);
  assign nrc   = (2*DW)'(ca) * (2*DW)'(cb);
  assign lim_c = (3*DW)'(nrc) * (3*DW)'(cc);
  assign total = (2*DW)'(ra) * (2*DW)'(rb);

  assign go = (ra != '0) && (ca != '0) && (rb != '0) && (cb != '0) && (cc != '0)
              && ({23'd0, pos} < 32'(cc));
  assign cb_full   = (3*DW)'(pos[DW-1:0]) * (3*DW)'(nrc);
  assign cbase_new = CW'(cb_full);

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_a_r <= '0;
      cols_a_r <= '0;
      rows_b_r <= '0;
      cols_b_r <= '0;
      cols_c_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        kpm_pkg::REG_ROWS_A: rows_a_r <= cfg_data;
        kpm_pkg::REG_COLS_A: cols_a_r <= cfg_data;
        kpm_pkg::REG_ROWS_B: rows_b_r <= cfg_data;
        kpm_pkg::REG_COLS_B: cols_b_r <= cfg_data;
        kpm_pkg::REG_COLS_C: cols_c_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // stall everything while an untaken result sits in the output register
  assign adv  = !out_v_r || out_tready;
  assign stg1 = (st_r == ST_ONE);
  assign iss  = adv && ((st_r == ST_ONE) || (st_r == ST_TWO));
  assign busy = p1v_r || mac_busy;

  assign kmax  = stg1 ? cb : ca;
  assign omax  = stg1 ? ca : ra;
  assign kl    = (k_r == kmax - DW'(1));
  assign k_end = kl && (stg1 || hi_r);
  assign m_end = (m_r == rb - DW'(1));
  assign o_end = (o_r == omax - DW'(1));

  always_comb begin
    beat.first  = (k_r == '0) && !hi_r;
    beat.last   = k_end;
    beat.stage2 = !stg1;
    beat.upper  = hi_r;
    beat.tail   = !stg1 && ((2*DW)'(dpi_r) + (2*DW)'(1) == total);
    beat.psat   = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      case (st_r)
        ST_IDLE: begin
          if (in_acc && (in_tuser == kpm_pkg::OP_COMPUTE) && go) begin
            st_r <= ST_ONE;
          end
        end
        ST_ONE: begin
          if (iss && k_end && m_end && o_end) begin
            st_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!busy) begin
            st_r <= ST_TWO;
          end
        end
        ST_TWO: begin
          if (iss && k_end && m_end && o_end) begin
            st_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!busy) begin
            st_r <= ST_IDLE;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  // loop counters and running addresses
  always_ff @(posedge clk) begin
    if (st_r == ST_IDLE) begin
      o_r     <= '0;
      m_r     <= '0;
      k_r     <= '0;
      hi_r    <= 1'b0;
      xp_r    <= '0;
      dpi_r   <= '0;
      yp_r    <= cbase_new;
      cbase_r <= cbase_new;
      col_r   <= pos[2:0];
    end else if (st_r == ST_DRAIN) begin
      o_r   <= '0;
      m_r   <= '0;
      k_r   <= '0;
      hi_r  <= 1'b0;
      xp_r  <= '0;
      yp_r  <= '0;
      dpi_r <= '0;
    end else if (iss) begin
      if (!stg1 && !hi_r) begin
        hi_r <= 1'b1;
      end else begin
        hi_r <= 1'b0;
        if (!kl) begin
          k_r  <= k_r + DW'(1);
          xp_r <= xp_r + AW'(rb);
          yp_r <= yp_r + (stg1 ? CW'(1) : CW'(ra));
        end else begin
          k_r   <= '0;
          dpi_r <= dpi_r + AW'(1);
          if (!m_end) begin
            m_r  <= m_r + DW'(1);
            xp_r <= AW'(m_r + DW'(1));
            yp_r <= stg1 ? cbase_r : CW'(o_r);
          end else begin
            m_r  <= '0;
            xp_r <= '0;
            if (!o_end) begin
              o_r     <= o_r + DW'(1);
              cbase_r <= cbase_r + CW'(cb);
              yp_r    <= stg1 ? cbase_r + CW'(cb) : CW'(o_r + DW'(1));
            end
          end
        end
      end
    end
  end

  // store writes and registered reads
  always_ff @(posedge clk) begin
    if (in_acc && (in_tuser == kpm_pkg::OP_LOAD_A) && ({23'd0, pos} < 32'(lim_a))) begin
      a_mem[pos[AW-1:0]] <= val;
    end
    if (in_acc && (in_tuser == kpm_pkg::OP_LOAD_B) && ({23'd0, pos} < 32'(lim_b))) begin
      b_mem[pos[AW-1:0]] <= val;
    end
    if (in_acc && (in_tuser == kpm_pkg::OP_LOAD_C) && ({23'd0, pos} < 32'(lim_c))) begin
      c_mem[CW'({23'd0, pos})] <= val;
    end
    if (adv && res_valid && !res_flags.stage2) begin
      p_mem[res_tag] <= {res_sat, res_value};
    end
    if (adv) begin
      a_rd_r <= a_mem[yp_r[AW-1:0]];
      b_rd_r <= b_mem[xp_r];
      c_rd_r <= c_mem[yp_r];
      p_rd_r <= p_mem[xp_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1v_r <= 1'b0;
    end else if (adv) begin
      p1v_r <= iss;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1f_r   <= beat;
      p1tag_r <= dpi_r;
    end
  end

  // operand select: B by C, or one half of a partial by A
  always_comb begin
    mflags      = p1f_r;
    mflags.psat = p1f_r.stage2 && p_rd_r[48];
    if (!p1f_r.stage2) begin
      op_x = {b_rd_r[31], b_rd_r};
      op_y = c_rd_r;
    end else if (p1f_r.upper) begin
      op_x = {{9{p_rd_r[47]}}, p_rd_r[47:24]};
      op_y = a_rd_r;
    end else begin
      op_x = {9'd0, p_rd_r[23:0]};
      op_y = a_rd_r;
    end
  end

  kpm_mac #(
    .FRAC_BITS (FRAC_BITS),
    .TW        (AW)
  ) u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (p1v_r),
    .in_flags  (mflags),
    .in_tag    (p1tag_r),
    .op_x      (op_x),
    .op_y      (op_y),
    .res_valid (res_valid),
    .res_flags (res_flags),
    .res_tag   (res_tag),
    .res_value (res_value),
    .res_sat   (res_sat),
    .busy      (mac_busy)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv && res_valid && res_flags.stage2) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_valid && res_flags.stage2) begin
      out_val_r  <= res_value[31:0];
      out_row_r  <= 6'({{(32-AW){1'b0}}, res_tag});
      out_col_r  <= col_r;
      out_sat_r  <= res_sat;
      out_last_r <= res_flags.tail;
    end
  end

  assign in_tready  = (st_r == ST_IDLE);
  assign out_tvalid = out_v_r;
  assign out_tdata  = {7'd0, out_col_r, out_row_r, out_val_r};
  assign out_tuser  = out_sat_r;
  assign out_tlast  = out_last_r;

  // new items only enter with an empty datapath
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !busy)
    else $error("input accepted while datapath busy");

  // a held result freezes the datapath
  a_hold_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_tready) |-> !adv)
    else $error("datapath advanced over an untaken result");

  // stage two starts only after all partials were written back
  a_drain_done: assert property (@(posedge clk) disable iff (!rst_n)
    ((st_r == ST_DRAIN) && !busy) |=> (st_r == ST_TWO) && !p1v_r)
    else $error("stage two started before partial store settled");

  // final results only come out of stage two
  a_result_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res_flags.stage2) |-> ((st_r == ST_TWO) || (st_r == ST_FIN)))
    else $error("result outside stage two");

endmodule

@@ test/kpm_checker.sv @@
// result checker for the kronecker product times matrix engine
// watches the config, input and result channels; needs kpm_pkg
// predicts each column in its own copy of the stores and compares word by word
module kpm_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [3:0]  cfg_data,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [47:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [47:0] out_tdata,
  input  logic        out_tuser,
  input  logic        out_tlast,
  output int          fail_count,
  output int          pending,
  output int          checked
);

  localparam int DIM_LIMIT = 8;

  typedef struct packed {
    logic [31:0] value;
    logic [5:0]  row;
    logic [2:0]  col;
    logic        sat;
    logic        last;
  } column_word_t;

  column_word_t column_words_q[$];
  logic [3:0]          size_reg [5];
  logic signed [31:0]  a_mem [64];
  logic signed [31:0]  b_mem [64];
  logic signed [31:0]  c_mem [512];
  logic signed [47:0]  p_mem [64];
  logic                p_clip [64];
  int                  mismatches = 0;
  int                  words_seen = 0;

  function automatic int clip_dim(logic [3:0] v);
    return (v > DIM_LIMIT) ? DIM_LIMIT : int'(v);
  endfunction

  // add half an lsb, drop 16 fraction bits, clamp to a signed field of the given width
  function automatic logic signed [63:0] round_clamp(input logic signed [127:0] acc,
                                                     input int bits, output logic clipped);
    logic signed [127:0] r, hi, lo;
    r  = (acc + 128'sd32768) >>> 16;
    hi = (128'sd1 <<< (bits - 1)) - 128'sd1;
    lo = -(128'sd1 <<< (bits - 1));
    clipped = (r > hi) || (r < lo);
    if (r > hi) r = hi;
    else if (r < lo) r = lo;
    return r[63:0];
  endfunction

  task automatic predict_column(input logic [8:0] pos);
    int ra, ca, rb, cb, cc, base, idx;
    logic signed [127:0] acc, x, y;
    logic signed [63:0] v;
    logic clipped, any;
    column_word_t w;
    ra = clip_dim(size_reg[kpm_pkg::REG_ROWS_A]);
    ca = clip_dim(size_reg[kpm_pkg::REG_COLS_A]);
    rb = clip_dim(size_reg[kpm_pkg::REG_ROWS_B]);
    cb = clip_dim(size_reg[kpm_pkg::REG_COLS_B]);
    cc = clip_dim(size_reg[kpm_pkg::REG_COLS_C]);
    if (ra == 0 || ca == 0 || rb == 0 || cb == 0 || cc == 0 || pos >= cc) return;
    base = pos * ca * cb;
    // first pass: B times the reshaped column
    for (int ka = 0; ka < ca; ka++) begin
      for (int i = 0; i < rb; i++) begin
        acc = '0;
        for (int kb = 0; kb < cb; kb++) begin
          x = b_mem[i + rb * kb];
          y = c_mem[base + kb + cb * ka];
          acc = acc + x * y;
        end
        v = round_clamp(acc, 48, clipped);
        p_mem[i + rb * ka]  = v[47:0];
        p_clip[i + rb * ka] = clipped;
      end
    end
    // second pass: partials times transpose of A, column-major out
    for (int r = 0; r < ra; r++) begin
      for (int i = 0; i < rb; i++) begin
        acc = '0;
        any = 1'b0;
        for (int ka = 0; ka < ca; ka++) begin
          x = p_mem[i + rb * ka];
          y = a_mem[r + ra * ka];
          acc = acc + x * y;
          any = any | p_clip[i + rb * ka];
        end
        v = round_clamp(acc, 32, clipped);
        idx = i + rb * r;
        w.value = v[31:0];
        w.row   = idx[5:0];
        w.col   = pos[2:0];
        w.sat   = clipped | any;
        w.last  = (idx == ra * rb - 1);
        column_words_q.push_back(w);
      end
    end
  endtask

  always @(posedge clk) begin
    logic [8:0]         pos;
    logic signed [31:0] val;
    column_word_t       got, want;
    if (!rst_n) begin
      for (int k = 0; k < 5; k++) size_reg[k] = '0;
      column_words_q.delete();
    end else begin
      if (cfg_valid && cfg_ready && cfg_index < 5) size_reg[cfg_index] = cfg_data;
      if (in_tvalid && in_tready) begin
        pos = in_tdata[8:0];
        val = in_tdata[40:9];
        case (in_tuser)
          kpm_pkg::OP_LOAD_A: begin
            if (pos < clip_dim(size_reg[kpm_pkg::REG_ROWS_A])
                      * clip_dim(size_reg[kpm_pkg::REG_COLS_A]))
              a_mem[pos] = val;
          end
          kpm_pkg::OP_LOAD_B: begin
            if (pos < clip_dim(size_reg[kpm_pkg::REG_ROWS_B])
                      * clip_dim(size_reg[kpm_pkg::REG_COLS_B]))
              b_mem[pos] = val;
          end
          kpm_pkg::OP_LOAD_C: begin
            if (pos < clip_dim(size_reg[kpm_pkg::REG_COLS_A])
                      * clip_dim(size_reg[kpm_pkg::REG_COLS_B])
                      * clip_dim(size_reg[kpm_pkg::REG_COLS_C]))
              c_mem[pos] = val;
          end
          default: predict_column(pos);
        endcase
      end
      if (out_tvalid && out_tready) begin
        got.value = out_tdata[31:0];
        got.row   = out_tdata[37:32];
        got.col   = out_tdata[40:38];
        got.sat   = out_tuser;
        got.last  = out_tlast;
        words_seen++;
        if (column_words_q.size() == 0) begin
          $display("%0t: unexpected word: value %h row %0d col %0d sat %0b last %0b",
                   $time, got.value, got.row, got.col, got.sat, got.last);
          mismatches++;
        end else begin
          want = column_words_q.pop_front();
          if (got.value !== want.value || got.row !== want.row || got.col !== want.col ||
              got.sat !== want.sat || got.last !== want.last || out_tdata[47:41] !== '0) begin
            $display("%0t: mismatch expected value %h row %0d col %0d sat %0b last %0b",
                     $time, want.value, want.row, want.col, want.sat, want.last);
            $display("%0t:          actual   value %h row %0d col %0d sat %0b last %0b",
                     $time, got.value, got.row, got.col, got.sat, got.last);
            mismatches++;
          end
        end
      end
    end
    fail_count <= mismatches;
    pending    <= column_words_q.size();
    checked    <= words_seen;
  end

endmodule

@@ test/kronecker_product_times_matrix_tb.sv @@
// testbench top for the kronecker product times matrix engine
// depends on kpm_pkg, kpm_checker and the block itself
// drives sizes, matrix loads and column computes; the checker predicts and compares
module kronecker_product_times_matrix_tb;

  localparam int CYCLE_LIMIT = 1000000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [3:0]  cfg_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;   // [8:0] position, [40:9] element_value
  logic [1:0]  in_tuser = '0;   // [1:0] operation
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;       // [31:0] value, [37:32] row, [40:38] column
  logic        out_tuser;       // [0] saturated
  logic        out_tlast;

  int fail_count, pending, checked;
  int send_idle = 0;            // percent of cycles the sender holds off
  int recv_idle = 0;            // percent of cycles the receiver stalls
  int words_sent = 0;
  int computes_sent = 0;
  int cycles = 0;
  // effective sizes, used to keep fills and column picks in range
  int ra, ca, rb, cb, cc;

  kronecker_product_times_matrix uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  kpm_checker check (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .fail_count(fail_count), .pending(pending), .checked(checked)
  );

  always #6 clk = ~clk;

  // receiver backpressure
  always @(posedge clk) begin
    out_tready <= (recv_idle == 0) || ($urandom_range(99) >= recv_idle);
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still expected", cycles, pending);
      $display("FAILED: results differ");
      $finish;
    end
  end

  function automatic int clip_dim(int v);
    return (v > 8) ? 8 : v;
  endfunction

  // mostly small values, a quarter full range so clipping shows up
  function automatic logic [31:0] pick_value();
    if ($urandom_range(3) == 0) return $urandom;
    return 32'($urandom_range(0, 1 << 19)) - 32'(1 << 18);
  endfunction

  // one word on the input channel; valid stays high unless the sender idles
  task automatic send_word(input logic [1:0] op, input logic [8:0] pos,
                           input logic [31:0] value);
    while (send_idle != 0 && $urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {7'b0, value, pos};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    words_sent++;
    if (op == kpm_pkg::OP_COMPUTE) computes_sent++;
  endtask

  // wait until every expected word is back and no compute is in flight
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    repeat (4) @(posedge clk);
    while (pending != 0 || !in_tready) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // write all five size registers back to back, only while idle
  task automatic set_sizes(input logic [3:0] v_ra, input logic [3:0] v_ca,
                           input logic [3:0] v_rb, input logic [3:0] v_cb,
                           input logic [3:0] v_cc);
    logic [3:0] vals [5];
    logic [2:0] regs [5];
    vals = '{v_ra, v_ca, v_rb, v_cb, v_cc};
    regs = '{kpm_pkg::REG_ROWS_A, kpm_pkg::REG_COLS_A, kpm_pkg::REG_ROWS_B,
             kpm_pkg::REG_COLS_B, kpm_pkg::REG_COLS_C};
    drain();
    for (int k = 0; k < 5; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= regs[k];
      cfg_data  <= vals[k];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
    ra = clip_dim(v_ra); ca = clip_dim(v_ca); rb = clip_dim(v_rb);
    cb = clip_dim(v_cb); cc = clip_dim(v_cc);
  endtask

  // load every in-range element so no compute reads an unwritten entry
  task automatic fill_all();
    for (int k = 0; k < ra * ca; k++) send_word(kpm_pkg::OP_LOAD_A, 9'(k), pick_value());
    for (int k = 0; k < rb * cb; k++) send_word(kpm_pkg::OP_LOAD_B, 9'(k), pick_value());
    for (int k = 0; k < ca * cb * cc; k++)
      send_word(kpm_pkg::OP_LOAD_C, 9'(k), pick_value());
  endtask

  initial begin
    int phase;
    int dims [5];
    logic [1:0] op;
    logic [8:0] pos;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: sizes all zero after reset, loads ignored and compute silent
    send_word(kpm_pkg::OP_LOAD_A, 9'd0, 32'h1234_5678);
    send_word(kpm_pkg::OP_COMPUTE, 9'd0, 32'h0);

    // directed: one by one matrices with extreme elements
    set_sizes(4'd1, 4'd1, 4'd1, 4'd1, 4'd1);
    send_word(kpm_pkg::OP_LOAD_A, 9'd0, 32'h8000_0000);
    send_word(kpm_pkg::OP_LOAD_B, 9'd0, 32'h7fff_ffff);
    send_word(kpm_pkg::OP_LOAD_C, 9'd0, 32'h0001_0000);
    send_word(kpm_pkg::OP_COMPUTE, 9'd0, 32'hffff_ffff);
    // column out of range and loads past the end are dropped
    send_word(kpm_pkg::OP_COMPUTE, 9'd1, 32'h0);
    send_word(kpm_pkg::OP_COMPUTE, 9'd511, 32'h0);
    send_word(kpm_pkg::OP_LOAD_A, 9'd511, 32'h7fff_ffff);
    send_word(kpm_pkg::OP_LOAD_B, 9'd1, 32'h7fff_ffff);
    send_word(kpm_pkg::OP_LOAD_C, 9'd256, 32'h7fff_ffff);
    // most negative squared fits the partial, then times the most negative A clips low
    send_word(kpm_pkg::OP_LOAD_B, 9'd0, 32'h8000_0000);
    send_word(kpm_pkg::OP_LOAD_C, 9'd0, 32'h8000_0000);
    send_word(kpm_pkg::OP_COMPUTE, 9'd0, 32'h0);
    // exact half lsb rounds toward plus infinity, both signs
    send_word(kpm_pkg::OP_LOAD_A, 9'd0, 32'h0001_0000);
    send_word(kpm_pkg::OP_LOAD_B, 9'd0, 32'h0000_0001);
    send_word(kpm_pkg::OP_LOAD_C, 9'd0, 32'h0000_8000);
    send_word(kpm_pkg::OP_COMPUTE, 9'd0, 32'h0);
    send_word(kpm_pkg::OP_LOAD_C, 9'd0, 32'hffff_8000);
    send_word(kpm_pkg::OP_COMPUTE, 9'd0, 32'h0);

    // directed: a zero size silences compute
    set_sizes(4'd1, 4'd1, 4'd1, 4'd0, 4'd1);
    send_word(kpm_pkg::OP_COMPUTE, 9'd0, 32'h0);

    // random phases, idling pattern rotates through the four modes
    phase = 0;
    while (words_sent < 260 || phase < 8) begin
      case (phase % 4)
        0: begin send_idle = 0;  recv_idle = 0;  end
        1: begin send_idle = 53; recv_idle = 0;  end
        2: begin send_idle = 0;  recv_idle = 53; end
        default: begin send_idle = 29; recv_idle = 29; end
      endcase
      case (phase)
        // largest result column; raw 15 acts as eight
        2: dims = '{15, 1, 8, 1, 8};
        // longest inner sums
        5: dims = '{1, 8, 1, 9, 1};
        // a zero size: only noise and silent computes
        6: dims = '{2, 0, 3, 1, 2};
        default: dims = '{$urandom_range(1, 3), $urandom_range(1, 3), $urandom_range(1, 3),
                          $urandom_range(1, 3), $urandom_range(1, 3)};
      endcase
      set_sizes(4'(dims[0]), 4'(dims[1]), 4'(dims[2]), 4'(dims[3]), 4'(dims[4]));
      fill_all();
      for (int k = 0; k < 6; k++) begin
        // once, in phase three, hold off until every column is back
        if (phase == 3 && k == 3) drain();
        case ($urandom_range(9))
          0: send_word(kpm_pkg::OP_COMPUTE, 9'($urandom_range(511)), $urandom);
          1, 2: begin
            op  = 2'($urandom_range(2));
            pos = ($urandom_range(1) == 0) ? 9'($urandom_range(511)) : 9'($urandom_range(7));
            // in-range overwrites are safe: everything was filled above
            send_word(op, pos, $urandom);
          end
          default: send_word(kpm_pkg::OP_COMPUTE,
                             9'($urandom_range((cc > 0) ? cc - 1 : 0)), $urandom);
        endcase
      end
      phase++;
    end

    drain();
    repeat (200) @(posedge clk);
    $display("sent %0d words (%0d computes) over %0d size settings; %0d result words checked",
             words_sent, computes_sent, phase + 3, checked);
    $display("covered clipping, rounding ties, out-of-range loads and columns, zero sizes");
    if (fail_count == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
